/* hw/rtl/calibration_and_shuttle_sequencer_core_macros.svh */
// Assertion macros shared by the sequencer checker.
`ifndef CALIBRATION_AND_SHUTTLE_SEQUENCER_CORE_MACROS_SVH
`define CALIBRATION_AND_SHUTTLE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CASS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CASS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

/* hw/rtl/cass_pkg.sv */
// Types, codes, reset values and helpers of the calibration and shuttle sequencer.
package cass_pkg;

    localparam int unsigned MS_W      = 16;
    localparam int unsigned ELAPSED_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [MS_W-1:0]      ms_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_POWER_ON_WAIT = 3'd1,
        CFG_STOP_WAIT     = 3'd2,
        CFG_ENTER_HOLD    = 3'd3,
        CFG_SHORT_HOLD    = 3'd4,
        CFG_SETTLE        = 3'd5,
        CFG_DONE_HOLD     = 3'd6,
        CFG_MOVE_REVS     = 3'd7
    } cfg_index_t;

    localparam ms_t DEBOUNCE_RST      = 16'd30;
    localparam ms_t POWER_ON_WAIT_RST = 16'd500;
    localparam ms_t STOP_WAIT_RST     = 16'd1000;
    localparam ms_t ENTER_HOLD_RST    = 16'd4200;
    localparam ms_t SHORT_HOLD_RST    = 16'd150;
    localparam ms_t SETTLE_RST        = 16'd800;
    localparam ms_t DONE_HOLD_RST     = 16'd1200;

    typedef enum logic [9:0] {
        CAL_IDLE         = 10'b00_0000_0001,
        CAL_WAIT_MOTOR   = 10'b00_0000_0010,
        CAL_ENTER_HOLD   = 10'b00_0000_0100,
        CAL_ENTER_SETTLE = 10'b00_0000_1000,
        CAL_WAIT_BLACK   = 10'b00_0001_0000,
        CAL_BLACK_HOLD   = 10'b00_0010_0000,
        CAL_BLACK_SETTLE = 10'b00_0100_0000,
        CAL_WAIT_WHITE   = 10'b00_1000_0000,
        CAL_WHITE_HOLD   = 10'b01_0000_0000,
        CAL_DONE         = 10'b10_0000_0000
    } cal_state_t;

    typedef enum logic [4:0] {
        MOV_POWER_WAIT = 5'b00001,
        MOV_POS_MOVE   = 5'b00010,
        MOV_POS_STOP   = 5'b00100,
        MOV_NEG_MOVE   = 5'b01000,
        MOV_NEG_STOP   = 5'b10000
    } move_state_t;

    // Numeric phase codes as shown on the result ports
    localparam logic [3:0] CALPH_IDLE         = 4'd0;
    localparam logic [3:0] CALPH_WAIT_MOTOR   = 4'd1;
    localparam logic [3:0] CALPH_ENTER_HOLD   = 4'd2;
    localparam logic [3:0] CALPH_ENTER_SETTLE = 4'd3;
    localparam logic [3:0] CALPH_WAIT_BLACK   = 4'd4;
    localparam logic [3:0] CALPH_BLACK_HOLD   = 4'd5;
    localparam logic [3:0] CALPH_BLACK_SETTLE = 4'd6;
    localparam logic [3:0] CALPH_WAIT_WHITE   = 4'd7;
    localparam logic [3:0] CALPH_WHITE_HOLD   = 4'd8;
    localparam logic [3:0] CALPH_DONE         = 4'd9;

    localparam logic [2:0] MOVPH_POWER_WAIT = 3'd0;
    localparam logic [2:0] MOVPH_POS_MOVE   = 3'd1;
    localparam logic [2:0] MOVPH_POS_STOP   = 3'd2;
    localparam logic [2:0] MOVPH_NEG_MOVE   = 3'd3;
    localparam logic [2:0] MOVPH_NEG_STOP   = 3'd4;

    localparam logic [1:0] START_NONE = 2'd0;
    localparam logic [1:0] START_POS  = 2'd1;
    localparam logic [1:0] START_NEG  = 2'd2;
    localparam logic [1:0] START_BAD  = 2'd3;

    function automatic ms_t sat_add(input ms_t a, input elapsed_t b);
        logic [MS_W:0] sum;
        sum = {1'b0, a} + {{(MS_W+1-ELAPSED_W){1'b0}}, b};
        return sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
    endfunction

    function automatic logic [3:0] cal_code(input cal_state_t s);
        logic [3:0] c;
        case (s)
            CAL_IDLE:         c = CALPH_IDLE;
            CAL_WAIT_MOTOR:   c = CALPH_WAIT_MOTOR;
            CAL_ENTER_HOLD:   c = CALPH_ENTER_HOLD;
            CAL_ENTER_SETTLE: c = CALPH_ENTER_SETTLE;
            CAL_WAIT_BLACK:   c = CALPH_WAIT_BLACK;
            CAL_BLACK_HOLD:   c = CALPH_BLACK_HOLD;
            CAL_BLACK_SETTLE: c = CALPH_BLACK_SETTLE;
            CAL_WAIT_WHITE:   c = CALPH_WAIT_WHITE;
            CAL_WHITE_HOLD:   c = CALPH_WHITE_HOLD;
            CAL_DONE:         c = CALPH_DONE;
            default:          c = CALPH_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] move_code(input move_state_t s);
        logic [2:0] c;
        case (s)
            MOV_POWER_WAIT: c = MOVPH_POWER_WAIT;
            MOV_POS_MOVE:   c = MOVPH_POS_MOVE;
            MOV_POS_STOP:   c = MOVPH_POS_STOP;
            MOV_NEG_MOVE:   c = MOVPH_NEG_MOVE;
            MOV_NEG_STOP:   c = MOVPH_NEG_STOP;
            default:        c = MOVPH_POWER_WAIT;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/calibration_and_shuttle_sequencer_core.sv */
// An accepted request passes from the input register into the state and result registers.
// Throughput: one request per cycle while results are taken; an input register feeds one pass
// of debounce, calibration and motion logic that writes the state and the result register together.
// A stalled result holds the input register; in_ready drops only while both are full.
// Reset (rst_n low, asynchronous): button released, calibration idle, motion in power
// wait, counters and key drive cleared, delay registers at their default values.
module calibration_and_shuttle_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cass_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cass_pkg::MS_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cass_pkg::ELAPSED_W-1:0]    ms_elapsed,
    input  logic                              button_level,
    input  logic                              motor_busy,
    input  logic                              start_accepted,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              press_event,
    output logic                              stop_request,
    output logic [1:0]                        start_command,
    output logic                              key_level,
    output logic [3:0]                        calibration_phase,
    output logic [2:0]                        motion_phase
);
    import cass_pkg::*;

    // delay registers; revolutions per move are not kept, no result depends on them
    ms_t debounce_ms_reg, power_on_wait_ms_reg, stop_wait_ms_reg, enter_hold_ms_reg;
    ms_t short_hold_ms_reg, settle_ms_reg, done_hold_ms_reg;

    // input stage
    logic     in_full_reg;
    elapsed_t ms_elapsed_reg;
    logic     button_level_reg, motor_busy_reg, start_accepted_reg;

    // sequencer state
    logic        raw_level_reg, raw_level_next;
    logic        stable_level_reg, stable_level_next;
    ms_t         since_raw_reg, since_raw_next;
    cal_state_t  cal_reg, cal_next;
    ms_t         since_cal_reg, since_cal_next;
    move_state_t move_reg, move_next;
    ms_t         since_move_reg, since_move_next;
    logic        key_drive_reg, key_drive_next;

    // result stage
    logic       out_valid_reg;
    logic       press_event_reg, press_event_next;
    logic       stop_request_reg, stop_request_next;
    logic [1:0] start_command_reg, start_command_next;

    logic advance, fire, take;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_full_reg && advance;
    assign in_ready = !in_full_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        raw_level_next     = raw_level_reg;
        stable_level_next  = stable_level_reg;
        since_raw_next     = sat_add(since_raw_reg, ms_elapsed_reg);
        since_cal_next     = sat_add(since_cal_reg, ms_elapsed_reg);
        since_move_next    = sat_add(since_move_reg, ms_elapsed_reg);
        cal_next           = cal_reg;
        move_next          = move_reg;
        key_drive_next     = key_drive_reg;
        press_event_next   = 1'b0;
        stop_request_next  = 1'b0;
        start_command_next = START_NONE;

        // debounce
        if (button_level_reg != raw_level_reg)
        begin
            raw_level_next = button_level_reg;
            since_raw_next = '0;
        end
        if (button_level_reg != stable_level_reg && since_raw_next >= debounce_ms_reg)
        begin
            stable_level_next = button_level_reg;
            press_event_next  = !button_level_reg;
        end

        // press only counts in idle, wait black and wait white
        if (press_event_next)
        begin
            case (cal_next)
                CAL_IDLE:
                begin
                    key_drive_next    = 1'b0;
                    stop_request_next = 1'b1;
                    cal_next          = CAL_WAIT_MOTOR;
                    since_cal_next    = '0;
                end
                CAL_WAIT_BLACK:
                begin
                    key_drive_next = 1'b1;
                    cal_next       = CAL_BLACK_HOLD;
                    since_cal_next = '0;
                end
                CAL_WAIT_WHITE:
                begin
                    key_drive_next = 1'b1;
                    cal_next       = CAL_WHITE_HOLD;
                    since_cal_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        // one calibration pass; a phase just entered is seen with zero elapsed time
        case (cal_next)
            CAL_IDLE, CAL_WAIT_BLACK, CAL_WAIT_WHITE:
            begin
            end
            CAL_WAIT_MOTOR:
            begin
                if (!motor_busy_reg)
                begin
                    key_drive_next = 1'b1;
                    cal_next       = CAL_ENTER_HOLD;
                    since_cal_next = '0;
                end
            end
            CAL_ENTER_HOLD:
            begin
                if (since_cal_next >= enter_hold_ms_reg)
                begin
                    key_drive_next = 1'b0;
                    cal_next       = CAL_ENTER_SETTLE;
                    since_cal_next = '0;
                end
            end
            CAL_ENTER_SETTLE:
            begin
                if (since_cal_next >= settle_ms_reg)
                begin
                    cal_next       = CAL_WAIT_BLACK;
                    since_cal_next = '0;
                end
            end
            CAL_BLACK_HOLD:
            begin
                if (since_cal_next >= short_hold_ms_reg)
                begin
                    key_drive_next = 1'b0;
                    cal_next       = CAL_BLACK_SETTLE;
                    since_cal_next = '0;
                end
            end
            CAL_BLACK_SETTLE:
            begin
                if (since_cal_next >= settle_ms_reg)
                begin
                    cal_next       = CAL_WAIT_WHITE;
                    since_cal_next = '0;
                end
            end
            CAL_WHITE_HOLD:
            begin
                if (since_cal_next >= short_hold_ms_reg)
                begin
                    key_drive_next = 1'b0;
                    cal_next       = CAL_DONE;
                    since_cal_next = '0;
                end
            end
            CAL_DONE:
            begin
                if (since_cal_next >= done_hold_ms_reg)
                begin
                    move_next       = MOV_POWER_WAIT;
                    since_move_next = '0;
                    cal_next        = CAL_IDLE;
                    since_cal_next  = '0;
                end
            end
            default:
            begin
                key_drive_next = 1'b0;
                cal_next       = CAL_IDLE;
                since_cal_next = '0;
            end
        endcase

        // shuttle runs only while calibration is idle
        if (cal_next == CAL_IDLE)
        begin
            case (move_next)
                MOV_POWER_WAIT:
                begin
                    if (since_move_next >= power_on_wait_ms_reg)
                    begin
                        start_command_next = START_POS;
                        if (start_accepted_reg)
                            move_next = MOV_POS_MOVE;
                    end
                end
                MOV_POS_MOVE:
                begin
                    if (!motor_busy_reg)
                    begin
                        move_next       = MOV_POS_STOP;
                        since_move_next = '0;
                    end
                end
                MOV_POS_STOP:
                begin
                    if (since_move_next >= stop_wait_ms_reg)
                    begin
                        start_command_next = START_NEG;
                        if (start_accepted_reg)
                            move_next = MOV_NEG_MOVE;
                    end
                end
                MOV_NEG_MOVE:
                begin
                    if (!motor_busy_reg)
                    begin
                        move_next       = MOV_NEG_STOP;
                        since_move_next = '0;
                    end
                end
                MOV_NEG_STOP:
                begin
                    if (since_move_next >= stop_wait_ms_reg)
                    begin
                        start_command_next = START_POS;
                        if (start_accepted_reg)
                            move_next = MOV_POS_MOVE;
                    end
                end
                default:
                begin
                    move_next       = MOV_POWER_WAIT;
                    since_move_next = '0;
                end
            endcase
        end
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg      <= DEBOUNCE_RST;
            power_on_wait_ms_reg <= POWER_ON_WAIT_RST;
            stop_wait_ms_reg     <= STOP_WAIT_RST;
            enter_hold_ms_reg    <= ENTER_HOLD_RST;
            short_hold_ms_reg    <= SHORT_HOLD_RST;
            settle_ms_reg        <= SETTLE_RST;
            done_hold_ms_reg     <= DONE_HOLD_RST;
            in_full_reg          <= 1'b0;
            out_valid_reg        <= 1'b0;
            raw_level_reg        <= 1'b1;
            stable_level_reg     <= 1'b1;
            since_raw_reg        <= '0;
            cal_reg              <= CAL_IDLE;
            since_cal_reg        <= '0;
            move_reg             <= MOV_POWER_WAIT;
            since_move_reg       <= '0;
            key_drive_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DEBOUNCE:      debounce_ms_reg      <= cfg_wdata;
                    CFG_POWER_ON_WAIT: power_on_wait_ms_reg <= cfg_wdata;
                    CFG_STOP_WAIT:     stop_wait_ms_reg     <= cfg_wdata;
                    CFG_ENTER_HOLD:    enter_hold_ms_reg    <= cfg_wdata;
                    CFG_SHORT_HOLD:    short_hold_ms_reg    <= cfg_wdata;
                    CFG_SETTLE:        settle_ms_reg        <= cfg_wdata;
                    CFG_DONE_HOLD:     done_hold_ms_reg     <= cfg_wdata;
                    CFG_MOVE_REVS:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (take)
                in_full_reg <= 1'b1;
            else if (fire)
                in_full_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                raw_level_reg    <= raw_level_next;
                stable_level_reg <= stable_level_next;
                since_raw_reg    <= since_raw_next;
                cal_reg          <= cal_next;
                since_cal_reg    <= since_cal_next;
                move_reg         <= move_next;
                since_move_reg   <= since_move_next;
                key_drive_reg    <= key_drive_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ms_elapsed_reg     <= ms_elapsed;
            button_level_reg   <= button_level;
            motor_busy_reg     <= motor_busy;
            start_accepted_reg <= start_accepted;
        end
        if (fire)
        begin
            press_event_reg   <= press_event_next;
            stop_request_reg  <= stop_request_next;
            start_command_reg <= start_command_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign press_event       = press_event_reg;
    assign stop_request      = stop_request_reg;
    assign start_command     = start_command_reg;
    // key and phases are the state after the last processed step
    assign key_level         = key_drive_reg;
    assign calibration_phase = cal_code(cal_reg);
    assign motion_phase      = move_code(move_reg);

endmodule

/* hw/rtl/cass_checker.sv */
// Port-level checker for the calibration and shuttle sequencer, bound to the top level.
`include "calibration_and_shuttle_sequencer_core_macros.svh"

module cass_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              press_event,
    input logic                              stop_request,
    input logic [1:0]                        start_command,
    input logic                              key_level,
    input logic [3:0]                        calibration_phase,
    input logic [2:0]                        motion_phase
);
    import cass_pkg::*;

    logic [11:0] result_bus;
    logic        leaving_idle;
    logic        in_hold_phase;

    assign result_bus    = {press_event, stop_request, start_command, key_level,
                            calibration_phase, motion_phase};
    assign leaving_idle  = calibration_phase inside {CALPH_WAIT_MOTOR, CALPH_ENTER_HOLD};
    assign in_hold_phase = calibration_phase inside {CALPH_ENTER_HOLD, CALPH_BLACK_HOLD,
                                                     CALPH_WHITE_HOLD};

    // a stalled result holds
    `CASS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bus))

    // a stop goes out only with the press that leaves idle
    `CASS_ASSERT_NOW(a_stop_on_press, out_valid && stop_request, press_event && leaving_idle)

    // the shuttle starts moves only while calibration is idle
    `CASS_ASSERT_NOW(a_start_idle, out_valid && start_command != START_NONE, calibration_phase == CALPH_IDLE && start_command != START_BAD)

    // the key is driven only in the hold phases
    `CASS_ASSERT_NOW(a_key_hold, out_valid && key_level, in_hold_phase)

endmodule

bind calibration_and_shuttle_sequencer_core cass_checker u_cass_checker (.*);
